// ----- rtl/core/sbsvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsvm_pkg
// Shared constants for the 16-bit stack processor core.
// ----------------------------------------------------------------------------
package sbsvm_pkg;

	localparam int unsigned MemWordsDefault   = 65536;
	localparam int unsigned StackDepthDefault = 256;

	localparam logic [2:0] StOk     = 3'd0;
	localparam logic [2:0] StNotReg = 3'd1;
	localparam logic [2:0] StEmpty  = 3'd2;
	localparam logic [2:0] StUnimpl = 3'd3;
	localparam logic [2:0] StFull   = 3'd4;

	localparam logic [15:0] OpHalt = 16'd0;
	localparam logic [15:0] OpSet  = 16'd1;
	localparam logic [15:0] OpPush = 16'd2;
	localparam logic [15:0] OpPop  = 16'd3;
	localparam logic [15:0] OpEq   = 16'd4;
	localparam logic [15:0] OpGt   = 16'd5;
	localparam logic [15:0] OpJmp  = 16'd6;
	localparam logic [15:0] OpJt   = 16'd7;
	localparam logic [15:0] OpJf   = 16'd8;
	localparam logic [15:0] OpAdd  = 16'd9;
	localparam logic [15:0] OpMult = 16'd10;
	localparam logic [15:0] OpMod  = 16'd11;
	localparam logic [15:0] OpAnd  = 16'd12;
	localparam logic [15:0] OpOr   = 16'd13;
	localparam logic [15:0] OpNot  = 16'd14;
	localparam logic [15:0] OpRmem = 16'd15;
	localparam logic [15:0] OpWmem = 16'd16;
	localparam logic [15:0] OpCall = 16'd17;
	localparam logic [15:0] OpRet  = 16'd18;
	localparam logic [15:0] OpOut  = 16'd19;
	localparam logic [15:0] OpIn   = 16'd20;
	localparam logic [15:0] OpNoop = 16'd21;

	localparam logic ItemLoad = 1'b0;

	// number of operand words fetched after the opcode word
	function automatic logic [1:0] operand_count(input logic [15:0] op);
		logic [1:0] n;
		n = 2'd0;
		unique case (op)
			OpSet, OpJt, OpJf, OpNot, OpRmem, OpWmem: n = 2'd2;
			OpPush, OpPop, OpJmp, OpCall, OpOut, OpIn: n = 2'd1;
			OpEq, OpGt, OpAdd, OpMult, OpMod, OpAnd, OpOr: n = 2'd3;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic is_reg(input logic [15:0] w);
		return w[15:3] == 13'h1000;
	endfunction

endpackage

// ----- rtl/core/sbsvm_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsvm_alu
// Shared arithmetic unit: registered ops plus a bit-serial 16-bit modulo.
// ----------------------------------------------------------------------------
module sbsvm_alu
	import sbsvm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] op,
	input  logic [15:0] x,
	input  logic [15:0] y,
	output logic        done,
	output logic [15:0] r
);

	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] y_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [31:0] prod;
	logic [16:0] sum;

	assign trial = {rem_q, quo_q[15]} - {1'b0, y_q};
	assign prod  = x * y;
	assign sum   = {1'b0, x} + {1'b0, y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
			r      <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			y_q    <= '0;
		end else begin
			done <= 1'b0;
			if (busy_q) begin
				quo_q <= {quo_q[14:0], 1'b0};
				if (!trial[16]) rem_q <= trial[15:0];
				else rem_q <= {rem_q[14:0], quo_q[15]};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					r      <= (!trial[16]) ? trial[15:0] : {rem_q[14:0], quo_q[15]};
				end
			end else if (go) begin
				unique case (op)
					OpMod: begin
						if (y == 16'd0) begin
							r    <= '0;
							done <= 1'b1;
						end else begin
							busy_q <= 1'b1;
							cnt_q  <= 5'd16;
							rem_q  <= '0;
							quo_q  <= x;
							y_q    <= y;
						end
					end
					OpEq:   begin r <= {15'd0, x == y}; done <= 1'b1; end
					OpGt:   begin r <= {15'd0, x > y};  done <= 1'b1; end
					OpAdd:  begin r <= {1'b0, sum[14:0]};  done <= 1'b1; end
					OpMult: begin r <= {1'b0, prod[14:0]}; done <= 1'b1; end
					OpAnd:  begin r <= x & y; done <= 1'b1; end
					OpOr:   begin r <= x | y; done <= 1'b1; end
					OpNot:  begin r <= {1'b0, ~x[14:0]}; done <= 1'b1; end
					default: begin r <= x; done <= 1'b1; end
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/sixteen_bit_stack_vm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixteen_bit_stack_vm_core
// 16-bit stack processor core: load memory words, step one instruction.
// ----------------------------------------------------------------------------
// A load transaction passes through S_LOAD before the next accept. A step
// fetches its words one at a time through the single memory read port
// (S_FADDR, S_FWAIT per word), decodes and commits; ALU ops add S_ALU and
// S_ALU_W (a mod by a nonzero divisor waits there), pop and ret add S_STK_W,
// rmem adds S_RMEM_A and S_RMEM_W; the path is set by words and opcode.
// Results appear for one cycle with done; the receiver cannot stall them.
module sixteen_bit_stack_vm_core
	import sbsvm_pkg::*;
#(
	parameter int unsigned MEM_WORDS   = MemWordsDefault,
	parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] load_address,
	input  logic [15:0] load_data,
	input  logic [7:0]  in_char,
	output logic        done,
	output logic [2:0]  status,
	output logic        out_valid,
	output logic [15:0] out_value,
	output logic        in_taken,
	output logic        halted,
	output logic [15:0] next_pc
);

	localparam int unsigned MemAw = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int unsigned StkAw = $clog2(STACK_DEPTH);
	localparam int unsigned CntW  = StkAw + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_FADDR, S_FWAIT, S_DECODE, S_RMEM_A, S_RMEM_W,
		S_STK_W, S_ALU, S_ALU_W, S_COMMIT
	} state_t;

	state_t state_q;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] stk [STACK_DEPTH];

	logic [15:0] pc_q, op_q, a_q, b_q, c_q, rdata_q, stk_rd_q;
	logic [1:0]  nops_q, idx_q;
	logic [CntW-1:0] sc_q;
	logic [15:0] regs_q [8];
	logic [7:0]  ch_q;
	logic        halt_q;
	logic        alu_go, alu_done;
	logic [15:0] alu_r;
	logic [15:0] xb, yc, xa;

	function automatic logic [15:0] opnd(input logic [15:0] w, input logic [15:0] rf [8]);
		logic [15:0] v;
		v = 16'd0;
		if (!w[15]) v = w;
		else if (is_reg(w)) v = rf[w[2:0]];
		return v;
	endfunction

	assign xa = opnd(a_q, regs_q);
	assign xb = opnd(b_q, regs_q);
	assign yc = opnd(c_q, regs_q);

	// memory: one write port and one read port, registered read, out-of-range reads give zero
	logic        mem_we;
	logic [15:0] mem_wa, mem_wd, mem_ra;
	logic        ra_ok_q;
	logic [15:0] mem_q;
	always_ff @(posedge clk) begin
		if (mem_we && ({16'd0, mem_wa} < 32'(MEM_WORDS))) mem[mem_wa[MemAw-1:0]] <= mem_wd;
		mem_q <= mem[mem_ra[MemAw-1:0]];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ra_ok_q <= 1'b0;
		else ra_ok_q <= {16'd0, mem_ra} < 32'(MEM_WORDS);
	end
	assign rdata_q = ra_ok_q ? mem_q : 16'd0;

	// stack: registered read of top entry
	logic             stk_we;
	logic [StkAw-1:0] stk_wa;
	logic [15:0]      stk_wd;
	logic [StkAw-1:0] stk_ra;
	always_ff @(posedge clk) begin
		if (stk_we) stk[stk_wa] <= stk_wd;
		stk_rd_q <= stk[stk_ra];
	end
	assign stk_ra = StkAw'(sc_q - CntW'(1));

	sbsvm_alu u_alu (
		.clk(clk), .arst_n(arst_n), .go(alu_go), .op(op_q), .x(xb), .y(yc),
		.done(alu_done), .r(alu_r)
	);

	assign busy = state_q != S_IDLE;
	assign alu_go = state_q == S_ALU;
	assign halted = halt_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = load_address;
		mem_wd = load_data;
		mem_ra = pc_q;
		if (state_q == S_IDLE && start && opcode == ItemLoad) mem_we = 1'b1;
		if (state_q == S_RMEM_A) mem_ra = xb;
		if (state_q == S_DECODE && op_q == OpWmem) begin
			mem_we = 1'b1;
			mem_wa = xa;
			mem_wd = xb;
		end
	end

	logic full;
	assign full = sc_q >= CntW'(STACK_DEPTH);

	always_comb begin
		stk_we = 1'b0;
		stk_wa = sc_q[StkAw-1:0];
		stk_wd = xa;
		if (state_q == S_DECODE && !full && (op_q == OpPush || op_q == OpCall)) begin
			stk_we = 1'b1;
			if (op_q == OpCall) stk_wd = pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			sc_q      <= '0;
			halt_q    <= 1'b0;
			done      <= 1'b0;
			status    <= StOk;
			out_valid <= 1'b0;
			out_value <= '0;
			in_taken  <= 1'b0;
			next_pc   <= '0;
			op_q      <= '0;
			a_q       <= '0;
			b_q       <= '0;
			c_q       <= '0;
			nops_q    <= '0;
			idx_q     <= '0;
			ch_q      <= '0;
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status    <= StOk;
						out_valid <= 1'b0;
						out_value <= '0;
						in_taken  <= 1'b0;
						ch_q      <= in_char;
						state_q   <= (opcode == ItemLoad) ? S_LOAD : S_FADDR;
						idx_q     <= '0;
						a_q <= '0; b_q <= '0; c_q <= '0;
					end
				end
				S_LOAD: begin
					done    <= 1'b1;
					next_pc <= pc_q;
					state_q <= S_IDLE;
				end
				S_FADDR: begin
					pc_q    <= pc_q + 16'd1;
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					if (idx_q == 2'd0) begin
						op_q   <= rdata_q;
						nops_q <= operand_count(rdata_q);
					end else if (idx_q == 2'd1) a_q <= rdata_q;
					else if (idx_q == 2'd2) b_q <= rdata_q;
					else c_q <= rdata_q;
					if ((idx_q == 2'd0 && operand_count(rdata_q) == 2'd0)
							|| (idx_q != 2'd0 && idx_q == nops_q))
						state_q <= S_DECODE;
					else state_q <= S_FADDR;
					idx_q <= idx_q + 2'd1;
				end
				S_DECODE: begin
					state_q <= S_COMMIT;
					priority case (op_q)
						OpHalt: halt_q <= 1'b1;
						OpNoop, OpWmem: ;
						OpSet, OpNot, OpEq, OpGt, OpAdd, OpMult, OpMod, OpAnd, OpOr: begin
							if (!is_reg(a_q)) status <= StNotReg;
							else state_q <= S_ALU;
						end
						OpRmem: begin
							if (!is_reg(a_q)) status <= StNotReg;
							else state_q <= S_RMEM_A;
						end
						OpPush: begin
							if (full) status <= StFull;
							else sc_q <= sc_q + CntW'(1);
						end
						OpCall: begin
							if (full) status <= StFull;
							else begin
								sc_q <= sc_q + CntW'(1);
								pc_q <= xa;
							end
						end
						OpPop: begin
							if (!is_reg(a_q)) status <= StNotReg;
							else if (sc_q == '0) status <= StEmpty;
							else state_q <= S_STK_W;
						end
						OpRet: begin
							if (sc_q == '0) status <= StEmpty;
							else state_q <= S_STK_W;
						end
						OpJmp: pc_q <= xa;
						OpJt: if (xa != 16'd0) pc_q <= xb;
						OpJf: if (xa == 16'd0) pc_q <= xb;
						OpOut: begin
							out_valid <= 1'b1;
							out_value <= xa;
						end
						OpIn: begin
							if (!is_reg(a_q)) status <= StNotReg;
							else begin
								regs_q[a_q[2:0]] <= {8'd0, ch_q};
								in_taken <= 1'b1;
							end
						end
						default: status <= StUnimpl;
					endcase
				end
				S_STK_W: begin
					sc_q <= sc_q - CntW'(1);
					if (op_q == OpRet) pc_q <= stk_rd_q;
					else regs_q[a_q[2:0]] <= stk_rd_q;
					state_q <= S_COMMIT;
				end
				S_RMEM_A: state_q <= S_RMEM_W;
				S_RMEM_W: begin
					regs_q[a_q[2:0]] <= rdata_q;
					state_q <= S_COMMIT;
				end
				S_ALU: state_q <= S_ALU_W;
				S_ALU_W: begin
					if (alu_done) begin
						regs_q[a_q[2:0]] <= alu_r;
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					done    <= 1'b1;
					next_pc <= pc_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/sbsvm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsvm_checker
// Port-level checks for the stack processor core.
// ----------------------------------------------------------------------------
module sbsvm_checker
	import sbsvm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic       out_valid,
	input logic       in_taken,
	input logic       halted
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without transaction");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == StOk || status == StNotReg || status == StEmpty
			|| status == StUnimpl || status == StFull)) else $error("bad status");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid && in_taken)) else $error("out and in together");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted) |-> halted) else $error("halt not sticky");

endmodule

bind sixteen_bit_stack_vm_core sbsvm_checker u_sbsvm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .out_valid(out_valid), .in_taken(in_taken), .halted(halted)
);

// ----- tb/sv/sixteen_bit_stack_vm_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixteen_bit_stack_vm_core_test
// Self-checking bench: loads programs word by word, steps the core one
// instruction at a time and checks every result against a behavioral model
// of the instruction set kept in the bench.
// ----------------------------------------------------------------------------
module sixteen_bit_stack_vm_core_test;
	import sbsvm_pkg::*;

	localparam int CycleLimit = 600000;
	localparam int StackWords = 256;

	typedef struct {
		logic        kind;
		logic [15:0] addr;
		logic [15:0] data;
		logic [7:0]  ch;
	} vm_item_t;

	typedef struct {
		logic [2:0]  st;
		logic        ov;
		logic [15:0] oval;
		logic        tk;
		logic        hlt;
		logic [15:0] npc;
	} vm_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        opcode;
	logic [15:0] load_address;
	logic [15:0] load_data;
	logic [7:0]  in_char;
	logic        done;
	logic [2:0]  status;
	logic        out_valid;
	logic [15:0] out_value;
	logic        in_taken;
	logic        halted;
	logic [15:0] next_pc;

	sixteen_bit_stack_vm_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.load_address(load_address), .load_data(load_data), .in_char(in_char),
		.done(done), .status(status), .out_valid(out_valid), .out_value(out_value),
		.in_taken(in_taken), .halted(halted), .next_pc(next_pc)
	);

	// shadow machine state
	logic [15:0] mem_m [65536];
	bit          written [65536];
	logic [15:0] regs_m [8];
	logic [15:0] stk_m [StackWords];
	int          sp_m;
	logic [15:0] pc_m;
	logic        hlt_m;

	vm_item_t   item_q[$];
	vm_result_t outcome_q[$];
	int         issued;
	int         accepted;
	int         errors;
	int         cycles;
	bit         took;
	int         burst_left;
	int         gap_left;

	function automatic bit reg_word(input logic [15:0] w);
		return w >= 16'd32768 && w <= 16'd32775;
	endfunction

	function automatic logic [15:0] opnd(input logic [15:0] w);
		if (w < 16'd32768)
			return w;
		if (reg_word(w))
			return regs_m[w[2:0]];
		return 16'd0;
	endfunction

	function automatic logic [15:0] fetch_word();
		logic [15:0] w;
		w = mem_m[pc_m];
		pc_m = pc_m + 16'd1;
		return w;
	endfunction

	function automatic int arg_words(input logic [15:0] op);
		case (op)
			OpSet, OpJt, OpJf, OpNot, OpRmem, OpWmem: return 2;
			OpPush, OpPop, OpJmp, OpCall, OpOut, OpIn: return 1;
			OpEq, OpGt, OpAdd, OpMult, OpMod, OpAnd, OpOr: return 3;
			default: return 0;
		endcase
	endfunction

	task automatic vm_execute(input vm_item_t it, output vm_result_t r);
		logic [15:0] op, a, b, c, v;
		logic [31:0] x, y;
		bit wr;
		r = '{default: '0};
		wr = 0;
		v = '0;
		a = '0;
		if (it.kind == ItemLoad) begin
			mem_m[it.addr] = it.data;
			written[it.addr] = 1;
		end else begin
			op = fetch_word();
			case (op)
				OpHalt: hlt_m = 1'b1;
				OpSet, OpNot, OpRmem: begin
					a = fetch_word();
					b = fetch_word();
					if (!reg_word(a)) begin
						r.st = StNotReg;
					end else begin
						x = opnd(b);
						if (op == OpSet)
							v = x[15:0];
						else if (op == OpNot)
							v = ~x[15:0] & 16'h7FFF;
						else
							v = mem_m[x[15:0]];
						wr = 1;
					end
				end
				OpPush: begin
					a = fetch_word();
					if (sp_m >= StackWords) begin
						r.st = StFull;
					end else begin
						stk_m[sp_m] = opnd(a);
						sp_m++;
					end
				end
				OpPop: begin
					a = fetch_word();
					if (!reg_word(a)) begin
						r.st = StNotReg;
					end else if (sp_m == 0) begin
						r.st = StEmpty;
					end else begin
						sp_m--;
						v = stk_m[sp_m];
						wr = 1;
					end
				end
				OpEq, OpGt, OpAdd, OpMult, OpMod, OpAnd, OpOr: begin
					a = fetch_word();
					b = fetch_word();
					c = fetch_word();
					if (!reg_word(a)) begin
						r.st = StNotReg;
					end else begin
						x = opnd(b);
						y = opnd(c);
						case (op)
							OpEq: v = (x == y) ? 16'd1 : 16'd0;
							OpGt: v = (x > y) ? 16'd1 : 16'd0;
							OpAdd: v = 16'((x + y) % 32768);
							OpMult: v = 16'((x * y) % 32768);
							OpMod: v = (y == 0) ? 16'd0 : 16'(x % y);
							OpAnd: v = 16'(x & y);
							default: v = 16'(x | y);
						endcase
						wr = 1;
					end
				end
				OpJmp: begin
					a = fetch_word();
					pc_m = opnd(a);
				end
				OpJt, OpJf: begin
					a = fetch_word();
					b = fetch_word();
					if ((opnd(a) != 0) == (op == OpJt))
						pc_m = opnd(b);
				end
				OpWmem: begin
					a = fetch_word();
					b = fetch_word();
					mem_m[opnd(a)] = opnd(b);
					written[opnd(a)] = 1;
				end
				OpCall: begin
					a = fetch_word();
					if (sp_m >= StackWords) begin
						r.st = StFull;
					end else begin
						stk_m[sp_m] = pc_m;
						sp_m++;
						pc_m = opnd(a);
					end
				end
				OpRet: begin
					if (sp_m == 0) begin
						r.st = StEmpty;
					end else begin
						sp_m--;
						pc_m = stk_m[sp_m];
					end
				end
				OpOut: begin
					a = fetch_word();
					r.ov = 1'b1;
					r.oval = opnd(a);
				end
				OpIn: begin
					a = fetch_word();
					if (!reg_word(a)) begin
						r.st = StNotReg;
					end else begin
						v = {8'd0, it.ch};
						r.tk = 1'b1;
						wr = 1;
					end
				end
				OpNoop: ;
				default: r.st = StUnimpl;
			endcase
			if (wr)
				regs_m[a[2:0]] = v;
		end
		r.hlt = hlt_m;
		r.npc = pc_m;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// stimulus helpers
	task automatic send(input vm_item_t t);
		item_q.push_back(t);
		issued++;
	endtask

	task automatic load_word(input logic [15:0] addr, input logic [15:0] data);
		vm_item_t t;
		t.kind = ItemLoad;
		t.addr = addr;
		t.data = data;
		t.ch = 8'($urandom_range(0, 255));
		send(t);
	endtask

	task automatic step_cpu();
		vm_item_t t;
		t.kind = ~ItemLoad;
		t.addr = 16'($urandom);
		t.data = 16'($urandom);
		t.ch = 8'($urandom_range(0, 255));
		send(t);
	endtask

	task automatic settle();
		wait (accepted == issued);
		@(negedge clk);
	endtask

	// places one instruction at the current pc, then executes it
	task automatic run_instr(input logic [15:0] op, input logic [15:0] a = 16'd0,
		input logic [15:0] b = 16'd0, input logic [15:0] c = 16'd0);
		logic [15:0] w [4];
		logic [15:0] p, ra;
		int n;
		settle();
		p = pc_m;
		n = arg_words(op);
		if (op == OpRmem) begin
			ra = opnd(b);
			if (!written[ra])
				load_word(ra, 16'($urandom));
		end
		w = '{op, a, b, c};
		for (int i = 0; i <= n; i++)
			load_word(p + 16'(i), w[i]);
		step_cpu();
	endtask

	function automatic logic [15:0] rreg(input int i);
		return 16'(32768 + i);
	endfunction

	function automatic logic [15:0] rnd_operand();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return rreg($urandom_range(0, 7));
		if (k < 60)
			return ($urandom_range(0, 1) != 0) ? 16'd0 : 16'd32767;
		if (k < 85)
			return 16'($urandom_range(0, 32767));
		return 16'($urandom_range(32776, 65535));
	endfunction

	function automatic logic [15:0] rnd_dest();
		if ($urandom_range(0, 9) == 0)
			return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 32767))
				: 16'($urandom_range(32776, 65535));
		return rreg($urandom_range(0, 7));
	endfunction

	task automatic fill_and_drain_stack();
		logic [15:0] base;
		int k;
		base = 16'd20000;
		run_instr(OpJmp, base);
		settle();
		load_word(base, OpCall);
		load_word(base + 16'd1, base);
		load_word(base + 16'd2, OpRet);
		settle();
		k = StackWords - sp_m;
		repeat (k + 1) step_cpu();
		repeat ((k < 16) ? k : 16) step_cpu();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// driver: accept check at the rising edge, drive at the falling edge
	always @(posedge clk) begin
		vm_item_t it;
		vm_result_t r;
		if (arst_n && start && !busy) begin
			it.kind = opcode;
			it.addr = load_address;
			it.data = load_data;
			it.ch = in_char;
			vm_execute(it, r);
			outcome_q.push_back(r);
			accepted++;
			took = 1;
		end
	end

	always @(negedge clk) begin
		vm_item_t it;
		if (arst_n && (!start || took)) begin
			took = 0;
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (item_q.size() > 0) begin
				it = item_q.pop_front();
				opcode <= it.kind;
				load_address <= it.addr;
				load_data <= it.data;
				in_char <= it.ch;
				start <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		vm_result_t e;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("unexpected transaction at %0t", $realtime);
				errors++;
			end else begin
				e = outcome_q.pop_front();
				if (status !== e.st) report_mismatch("status", 16'(status), 16'(e.st));
				if (out_valid !== e.ov)
					report_mismatch("out_valid", 16'(out_valid), 16'(e.ov));
				if (out_value !== e.oval) report_mismatch("out_value", out_value, e.oval);
				if (in_taken !== e.tk) report_mismatch("in_taken", 16'(in_taken), 16'(e.tk));
				if (halted !== e.hlt) report_mismatch("halted", 16'(halted), 16'(e.hlt));
				if (next_pc !== e.npc) report_mismatch("next_pc", next_pc, e.npc);
			end
		end
	end

	initial begin
		int k;
		logic [15:0] op;
		start = 1'b0;
		opcode = ItemLoad;
		load_address = '0;
		load_data = '0;
		in_char = '0;
		took = 0;
		issued = 0;
		accepted = 0;
		errors = 0;
		cycles = 0;
		burst_left = 1;
		gap_left = 0;
		for (int i = 0; i < 8; i++)
			regs_m[i] = '0;
		sp_m = 0;
		pc_m = '0;
		hlt_m = 1'b0;
		wait (arst_n === 1'b1);

		// directed
		load_word(16'hFFFF, 16'hFFFF);
		load_word(16'h0000, 16'h0000);
		run_instr(OpHalt);
		run_instr(OpSet, rreg(0), 16'd32767);
		run_instr(OpAdd, rreg(1), rreg(0), rreg(0));
		run_instr(OpMult, rreg(2), rreg(0), rreg(0));
		run_instr(OpMod, rreg(3), rreg(0), 16'd0);
		run_instr(OpMod, rreg(3), rreg(0), 16'd10);
		run_instr(OpNot, rreg(4), 16'd0);
		run_instr(OpAnd, rreg(5), rreg(0), 16'h5555);
		run_instr(OpOr, rreg(5), rreg(5), 16'h2AAA);
		run_instr(OpEq, rreg(6), rreg(0), 16'd32767);
		run_instr(OpGt, rreg(6), rreg(0), 16'd40000);
		run_instr(OpSet, 16'd5, 16'd1);
		run_instr(OpPop, rreg(0));
		run_instr(OpPop, 16'd40000);
		run_instr(OpRet);
		run_instr(OpPush, rreg(1));
		run_instr(OpPop, rreg(7));
		run_instr(OpOut, rreg(2));
		run_instr(OpOut, 16'd40000);
		run_instr(OpIn, rreg(6));
		run_instr(OpIn, 16'd7);
		run_instr(OpNoop);
		run_instr(16'd22);
		run_instr(16'hFFFF);
		run_instr(OpJt, rreg(0), 16'd100);
		run_instr(OpJf, rreg(0), 16'd100);
		run_instr(OpJmp, 16'd200);
		run_instr(OpCall, 16'd300);
		run_instr(OpRet);
		run_instr(OpWmem, 16'd500, rreg(0));
		run_instr(OpRmem, rreg(7), 16'd500);
		// pc wrap: fetch the target through memory, jump, run across the top
		settle();
		load_word(16'd1000, 16'd65534);
		run_instr(OpRmem, rreg(7), 16'd1000);
		run_instr(OpJmp, rreg(7));
		run_instr(OpSet, rreg(0), 16'd123);

		// random
		k = 0;
		while (issued < 600) begin
			if ($urandom_range(0, 9) == 0) begin
				settle();
				load_word(16'($urandom), 16'($urandom));
			end else begin
				if ($urandom_range(0, 19) == 0)
					op = 16'($urandom_range(22, 65535));
				else
					op = 16'($urandom_range(0, 21));
				case (op)
					OpJmp, OpCall:
						run_instr(op, ($urandom_range(0, 3) == 0) ? rnd_operand()
							: 16'($urandom_range(0, 32767)));
					OpJt, OpJf:
						run_instr(op, rnd_operand(), 16'($urandom_range(0, 32767)));
					OpWmem, OpPush, OpOut:
						run_instr(op, rnd_operand(), rnd_operand());
					default:
						run_instr(op, rnd_dest(), rnd_operand(), rnd_operand());
				endcase
			end
			k++;
			if (k == 20)
				fill_and_drain_stack();
		end

		wait (accepted == issued);
		wait (outcome_q.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
